>>> rtl/serpentine_error_diffusion_halftone_assert.svh
// Assertion macros for the serpentine halftoner.
// Needs nothing else; the halftoner, which checks its own logic, includes it.
`ifndef SERPENTINE_ERROR_DIFFUSION_HALFTONE_ASSERT_SVH
`define SERPENTINE_ERROR_DIFFUSION_HALFTONE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEDH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("halftoner check failed");

// The consequent must hold in the cycle after the antecedent.
`define SEDH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("halftoner check failed");

`endif

>>> rtl/sedh_pkg.sv
// Shared types, constants and arithmetic helpers of the serpentine halftoner.
// No dependencies; the RTL files refer to it by scoped names and the testbench imports it.
package sedh_pkg;

    // Field and register widths.
    localparam int GRAY_W      = 8;
    localparam int ERR_W       = 11;
    localparam int WIDTH_CFG_W = 13;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    // Register values after reset.
    localparam logic [WIDTH_CFG_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [HEIGHT_W-1:0]    RESET_HEIGHT = 16'd480;

    // Quantizer levels.
    localparam logic signed [ERR_W-1:0] THRESHOLD = 11'sd128;
    localparam logic signed [ERR_W-1:0] WHITE_ERR = 11'sd255;
    localparam logic [GRAY_W-1:0]       WHITE     = 8'd255;
    localparam logic [GRAY_W-1:0]       BLACK     = 8'd0;

    // Output queue depth and its counter width.
    localparam int OQ_DEPTH = 3;
    localparam int OQ_CNT_W = 2;

    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        logic [GRAY_W-1:0] halftone_value;
        logic              row_end;
        logic              image_end;
    } t_result;

    // Clamp a wide sum into the 11-bit signed error range.
    function automatic t_err sat11(input logic signed [13:0] v);
        t_err res;
        if (v < -14'sd1024) begin
            res = -11'sd1024;
        end else if (v > 14'sd1023) begin
            res = 11'sd1023;
        end else begin
            res = v[ERR_W-1:0];
        end
        return res;
    endfunction

    // Divide by 16 with truncation toward zero.
    function automatic t_err div16_trunc(input logic signed [13:0] v);
        logic signed [14:0] adj;
        logic signed [14:0] shifted;
        adj     = {v[13], v} + (v[13] ? 15'sd15 : 15'sd0);
        shifted = adj >>> 4;
        return shifted[ERR_W-1:0];
    endfunction

endpackage

>>> rtl/sedh_ifs.sv
// Handshake channels of the serpentine halftoner: pixels, results, register writes.
// Depends on sedh_pkg for field widths.
interface sedh_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [sedh_pkg::GRAY_W-1:0]   gray_level;
    modport source (output valid, output gray_level, input ready);
    modport sink (input valid, input gray_level, output ready);
endinterface

interface sedh_result_if;
    logic                          valid;
    logic                          ready;
    logic [sedh_pkg::GRAY_W-1:0]   halftone_value;
    logic                          row_end;
    logic                          image_end;
    modport source (output valid, output halftone_value, output row_end,
                    output image_end, input ready);
    modport sink (input valid, input halftone_value, input row_end,
                  input image_end, output ready);
endinterface

interface sedh_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sedh_pkg::CFG_IDX_W-1:0]    index;
    logic [sedh_pkg::CFG_DATA_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/serpentine_error_diffusion_halftone.sv
// Serpentine error-diffusion halftoner: one gray pixel in, one binary pixel out.
// A result is registered in the second stage and then in the output queue, whose head drives the channel.
// Throughput: one pixel per cycle while running with queue room, set by one buffer read
// and write per pixel. Reset clears all state and sweeps the line buffer; the same sweep
// follows an image whose sizes were rewritten mid-image, which also costs a resync.
`include "serpentine_error_diffusion_halftone_assert.svh"

module serpentine_error_diffusion_halftone #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sedh_cfg_if.sink       i_cfg,
    sedh_pixel_if.sink     i_pixel,
    sedh_result_if.source  o_result
);

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > sedh_pkg::WIDTH_CFG_W) ? WW : sedh_pkg::WIDTH_CFG_W;
    localparam logic [CMPW-1:0] MAX_W_C   = CMPW'(MAX_WIDTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(MAX_WIDTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_RUN    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_FLUSH  = 3'd3;
    localparam logic [2:0] S_RELOAD = 3'd4;
    localparam logic [2:0] S_LOAD   = 3'd5;

    typedef struct packed {
        logic [sedh_pkg::GRAY_W-1:0] gray;
        logic [AW-1:0]               x;
        logic                        last_col;
        logic                        last_row;
        logic                        add_behind;
    } t_stage;

    // Registers.
    logic [sedh_pkg::WIDTH_CFG_W-1:0] r_image_width;
    logic [sedh_pkg::HEIGHT_W-1:0]    r_image_height;
    logic [2:0]                       r_state;
    logic [2:0]                       n_state;
    logic [AW-1:0]                    r_clr;
    logic                             r_dirty;
    logic [AW-1:0]                    r_col;
    logic [sedh_pkg::HEIGHT_W-1:0]    r_row;
    logic                             r_b_valid;
    t_stage                           r_b;
    sedh_pkg::t_err                   r_carry;
    sedh_pkg::t_err                   r_diag;
    sedh_pkg::t_err                   r_pend;
    logic [AW-1:0]                    r_xprev;
    sedh_pkg::t_err                   r_err_mem [MAX_WIDTH];
    sedh_pkg::t_err                   r_rdata;
    logic                             r_fwd_hit;
    sedh_pkg::t_err                   r_fwd_data;

    // Combinational signals.
    logic                             cfg_acc;
    logic                             pix_acc;
    logic                             mid_image;
    logic [CMPW-1:0]                  w_ext;
    logic [CMPW-1:0]                  w_clamp;
    logic [CMPW-1:0]                  w_last_full;
    logic [AW-1:0]                    w_last;
    logic [sedh_pkg::HEIGHT_W-1:0]    h_last;
    logic                             a_last_col;
    logic                             a_last_row;
    logic                             a_rtl;
    logic [AW-1:0]                    a_col;
    logic [AW-1:0]                    a_x;
    logic                             a_behind_ok;
    logic [AW-1:0]                    a_behind;
    logic [sedh_pkg::OQ_CNT_W-1:0]    q_count;
    logic [2:0]                       in_flight;
    sedh_pkg::t_err                   buf_val;
    logic signed [13:0]               acc_sum;
    sedh_pkg::t_err                   acc;
    logic                             white;
    sedh_pkg::t_err                   err_val;
    logic signed [13:0]               err14;
    sedh_pkg::t_err                   s7;
    sedh_pkg::t_err                   s3;
    sedh_pkg::t_err                   s5;
    sedh_pkg::t_err                   s1;
    sedh_pkg::t_err                   pend_new;
    sedh_pkg::t_err                   wdata_b;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    sedh_pkg::t_err                   mem_wdata;
    logic [AW-1:0]                    mem_raddr;
    sedh_pkg::t_result                push_data;

    // Handshakes.
    assign cfg_acc       = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready   = 1'b1;
    assign in_flight     = 3'(q_count) + 3'(r_b_valid);
    assign i_pixel.ready = (r_state == S_RUN) && (in_flight < 3'(sedh_pkg::OQ_DEPTH));
    assign pix_acc       = i_pixel.valid && i_pixel.ready;
    assign mid_image     = (r_col != '0) || (r_row != '0);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sedh_pkg::RESET_WIDTH;
            r_image_height <= sedh_pkg::RESET_HEIGHT;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                sedh_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg.data[sedh_pkg::WIDTH_CFG_W-1:0];
                end
                sedh_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // Effective sizes: zero acts as one, width is capped at the buffer depth.
    always_comb begin
        w_ext = CMPW'(r_image_width);
        if (w_ext == '0) begin
            w_clamp = CMPW'(1);
        end else if (w_ext > MAX_W_C) begin
            w_clamp = MAX_W_C;
        end else begin
            w_clamp = w_ext;
        end
        w_last_full = w_clamp - CMPW'(1);
        w_last      = w_last_full[AW-1:0];
        h_last      = (r_image_height == '0) ? '0 : r_image_height - 1'b1;
    end

    // Position of the next pixel and of the column behind it.
    always_comb begin
        a_last_col  = (r_col >= w_last);
        a_last_row  = (r_row >= h_last);
        a_col       = a_last_col ? w_last : r_col;
        a_rtl       = ~r_row[0];
        a_x         = a_rtl ? (w_last - a_col) : a_col;
        a_behind_ok = a_rtl ? (a_x != w_last) : (a_x != '0);
        a_behind    = a_rtl ? (a_x + 1'b1) : (a_x - 1'b1);
    end

    // Column and row counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (pix_acc) begin
            if (a_last_col) begin
                r_col <= '0;
                r_row <= a_last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Second stage holds the pixel while its buffer entry is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_b.gray       <= i_pixel.gray_level;
            r_b.x          <= a_x;
            r_b.last_col   <= a_last_col;
            r_b.last_row   <= a_last_row;
            r_b.add_behind <= a_behind_ok && !a_last_row;
        end
    end

    // Sequencer: buffer sweep, normal flow and resync after a size change.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (cfg_acc && mid_image) begin
                    n_state = S_FLUSH;
                end else if (pix_acc && a_last_col && a_last_row && r_dirty) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CLEAR;
            end
            S_FLUSH: begin
                n_state = cfg_acc ? S_FLUSH : S_RELOAD;
            end
            S_RELOAD: begin
                if (cfg_acc) begin
                    n_state = S_FLUSH;
                end else if (a_behind_ok) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_LOAD: begin
                n_state = cfg_acc ? S_FLUSH : S_RUN;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end else begin
                r_clr <= '0;
            end
            if (r_state == S_DRAIN) begin
                r_dirty <= 1'b0;
            end else if (cfg_acc && mid_image) begin
                r_dirty <= 1'b1;
            end
        end
    end

    // Error datapath: the entry value takes the newest pending or just-written data.
    always_comb begin
        if (r_b.x == r_xprev) begin
            buf_val = r_pend;
        end else if (r_fwd_hit) begin
            buf_val = r_fwd_data;
        end else begin
            buf_val = r_rdata;
        end
        acc_sum  = $signed({6'd0, r_b.gray}) + 14'(r_carry) + 14'(buf_val);
        acc      = sedh_pkg::sat11(acc_sum);
        white    = (acc >= sedh_pkg::THRESHOLD);
        err_val  = acc - (white ? sedh_pkg::WHITE_ERR : 11'sd0);
        err14    = 14'(err_val);
        s7       = sedh_pkg::div16_trunc((err14 <<< 3) - err14);
        s3       = sedh_pkg::div16_trunc((err14 <<< 1) + err14);
        s5       = sedh_pkg::div16_trunc((err14 <<< 2) + err14);
        s1       = sedh_pkg::div16_trunc(err14);
        pend_new = r_b.last_row ? '0 : sedh_pkg::sat11(14'(s5) + 14'(r_diag));
        wdata_b  = r_b.add_behind ? sedh_pkg::sat11(14'(r_pend) + 14'(s3)) : r_pend;
    end

    // Error registers; the pending entry is written back one pixel later.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_diag  <= '0;
            r_pend  <= '0;
            r_xprev <= '0;
        end else if (r_state == S_LOAD) begin
            r_pend <= r_rdata;
        end else if (r_state == S_RELOAD) begin
            if (!cfg_acc && a_behind_ok) begin
                r_xprev <= a_behind;
            end
        end else if (r_b_valid) begin
            r_carry <= r_b.last_col ? '0 : s7;
            r_diag  <= (r_b.last_col || r_b.last_row) ? '0 : s1;
            r_pend  <= pend_new;
            r_xprev <= r_b.x;
        end
    end

    // Line buffer port selection.
    always_comb begin
        mem_raddr = (r_state == S_RELOAD) ? a_behind : a_x;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
            end
            S_FLUSH: begin
                mem_we    = 1'b1;
                mem_waddr = r_xprev;
                mem_wdata = r_pend;
            end
            default: begin
                mem_we    = r_b_valid;
                mem_waddr = r_xprev;
                mem_wdata = wdata_b;
            end
        endcase
    end

    // Line buffer: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_err_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata    <= r_err_mem[mem_raddr];
        r_fwd_hit  <= mem_we && (mem_waddr == mem_raddr);
        r_fwd_data <= mem_wdata;
    end

    // Result formatting and output queue.
    always_comb begin
        push_data.halftone_value = white ? sedh_pkg::WHITE : sedh_pkg::BLACK;
        push_data.row_end        = r_b.last_col;
        push_data.image_end      = r_b.last_col && r_b.last_row;
    end

    sedh_out_queue u_out_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_b_valid),
        .i_push_data (push_data),
        .o_count     (q_count),
        .o_result    (o_result)
    );

    // Checks.
    `SEDH_ASSERT_IMP(a_inflight_bound, i_clk, i_rst_n, 1'b1, in_flight <= 3'(sedh_pkg::OQ_DEPTH))
    `SEDH_ASSERT_IMP(a_image_end_row_end, i_clk, i_rst_n, o_result.valid && o_result.image_end, o_result.row_end)
    `SEDH_ASSERT_IMP(a_binary_out, i_clk, i_rst_n, o_result.valid, (o_result.halftone_value == sedh_pkg::WHITE) || (o_result.halftone_value == sedh_pkg::BLACK))
    `SEDH_ASSERT_NEXT(a_image_wrap, i_clk, i_rst_n, pix_acc && a_last_col && a_last_row, (r_col == '0) && (r_row == '0))
    `SEDH_ASSERT_NEXT(a_clear_walk, i_clk, i_rst_n, (r_state == S_CLEAR) && (r_clr != LAST_ADDR), r_clr == AW'($past(r_clr) + 1'b1))

endmodule

>>> rtl/sedh_out_queue.sv
// Three-entry result queue that decouples the error datapath from the consumer.
// Depends on sedh_pkg and the result channel interface.
module sedh_out_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  sedh_pkg::t_result             i_push_data,
    output logic [sedh_pkg::OQ_CNT_W-1:0] o_count,
    sedh_result_if.source                 o_result
);

    sedh_pkg::t_result                  r_entries [sedh_pkg::OQ_DEPTH];
    logic [sedh_pkg::OQ_CNT_W-1:0]      r_wr_ptr;
    logic [sedh_pkg::OQ_CNT_W-1:0]      r_rd_ptr;
    logic [sedh_pkg::OQ_CNT_W-1:0]      r_count;
    logic                               pop;
    sedh_pkg::t_result                  head;

    localparam logic [sedh_pkg::OQ_CNT_W-1:0] LAST_PTR =
        sedh_pkg::OQ_CNT_W'(sedh_pkg::OQ_DEPTH - 1);

    // The head entry drives the channel directly.
    assign pop                     = o_result.valid && o_result.ready;
    assign head                    = r_entries[r_rd_ptr];
    assign o_result.valid          = (r_count != '0);
    assign o_result.halftone_value = head.halftone_value;
    assign o_result.row_end        = head.row_end;
    assign o_result.image_end      = head.image_end;
    assign o_count                 = r_count;

    // Entry storage; written only at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10: begin
                    r_count <= r_count + 1'b1;
                end
                2'b01: begin
                    r_count <= r_count - 1'b1;
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serpentine error-diffusion halftoner.
// Needs sedh_pkg, the sedh channel interfaces and the halftoner RTL.

module testbench;
    import sedh_pkg::*;

    localparam int LINE_DEPTH = 4096;
    localparam int ERR_LO = -1024;
    localparam int ERR_HI = 1023;
    localparam int PIXEL_TARGET = 1900;

    // Register indexes past the end of the register list; writes to them are ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_IMAGE_HEIGHT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

    // Predicts the halftone stream and holds the results still to come.
    class halftone_scoreboard;
        t_err                   line_err[LINE_DEPTH];
        t_err                   carry_err;
        t_err                   diag_err;
        logic [11:0]            col_pos;
        logic [15:0]            row_pos;
        logic [WIDTH_CFG_W-1:0] width_reg;
        logic [HEIGHT_W-1:0]    height_reg;
        t_result                expected_q[$];
        int                     mismatches;

        function new();
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            mismatches = 0;
            clear_image();
        endfunction

        // Everything that is carried from pixel to pixel goes back to zero.
        function void clear_image();
            foreach (line_err[i]) line_err[i] = '0;
            carry_err = '0;
            diag_err  = '0;
            col_pos   = '0;
            row_pos   = '0;
        endfunction

        static function int clip_err(int v);
            if (v < ERR_LO) return ERR_LO;
            if (v > ERR_HI) return ERR_HI;
            return v;
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_IMAGE_WIDTH) width_reg = data[WIDTH_CFG_W-1:0];
            else if (idx == REG_IMAGE_HEIGHT) height_reg = data[HEIGHT_W-1:0];
        endfunction

        // Quantize one accepted pixel and spread its error.
        function void note_pixel(logic [GRAY_W-1:0] gray);
            int      w, h, c, x, acc, err, s7, s3, s5, s1;
            bit      last_col, last_row, right_to_left;
            t_result res;
            w = int'(width_reg);
            if (w == 0) w = 1;
            if (w > LINE_DEPTH) w = LINE_DEPTH;
            h = int'(height_reg);
            if (h == 0) h = 1;
            last_col = int'(col_pos) >= w - 1;
            last_row = int'(row_pos) >= h - 1;
            c = last_col ? w - 1 : int'(col_pos);
            right_to_left = !row_pos[0];
            x = right_to_left ? w - 1 - c : c;

            acc = clip_err(int'(gray) + int'(carry_err) + int'(line_err[x]));
            res.halftone_value = (acc >= int'(THRESHOLD)) ? WHITE : BLACK;
            res.row_end = last_col;
            res.image_end = last_col && last_row;
            expected_q.push_back(res);

            // Shares truncate toward zero, as integer division does.
            err = acc - int'(res.halftone_value);
            s7 = (err * 7) / 16;
            s3 = (err * 3) / 16;
            s5 = (err * 5) / 16;
            s1 = err / 16;

            // The last row passes nothing down; otherwise update the columns behind and below.
            if (last_row) begin
                line_err[x] = '0;
            end else begin
                if (right_to_left) begin
                    if (x + 1 < w) line_err[x+1] = t_err'(clip_err(int'(line_err[x+1]) + s3));
                end else if (x >= 1) begin
                    line_err[x-1] = t_err'(clip_err(int'(line_err[x-1]) + s3));
                end
                line_err[x] = t_err'(clip_err(s5 + int'(diag_err)));
            end

            if (last_col) begin
                carry_err = '0;
                diag_err  = '0;
                col_pos   = '0;
                if (last_row) clear_image();
                else row_pos = row_pos + 16'd1;
            end else begin
                carry_err = t_err'(clip_err(s7));
                diag_err  = last_row ? t_err'(0) : t_err'(clip_err(s1));
                col_pos   = col_pos + 12'd1;
            end
        endfunction

        function void flag(string msg);
            if (mismatches < 10) $display("%s", msg);
            mismatches++;
        endfunction

        function void check_result(logic [GRAY_W-1:0] value, logic row_end, logic image_end);
            t_result want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result: value %0d row_end %0b image_end %0b",
                               value, row_end, image_end));
            end else begin
                want = expected_q.pop_front();
                if (value !== want.halftone_value || row_end !== want.row_end ||
                    image_end !== want.image_end) begin
                    flag($sformatf({"result mismatch: expected value %0d row_end %0b ",
                                    "image_end %0b, got value %0d row_end %0b image_end %0b"},
                                   want.halftone_value, want.row_end, want.image_end,
                                   value, row_end, image_end));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sedh_pixel_if  pixel_ch();
    sedh_result_if result_ch();
    sedh_cfg_if    cfg_ch();

    serpentine_error_diffusion_halftone #(
        .MAX_WIDTH(LINE_DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pixel (pixel_ch),
        .o_result(result_ch)
    );

    halftone_scoreboard sb;
    bit quiet_flow = 1'b0;
    int pixels_sent = 0;
    int stall_left = 0;

    always #5 i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, none while the flow is quiet.
    function automatic int pick_gap();
        int r;
        if (quiet_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Extremes, values around the threshold, flat areas and plain noise.
    function automatic logic [GRAY_W-1:0] pick_gray(int flat_level);
        int r;
        r = $urandom_range(0, 9);
        if (flat_level >= 0 && r < 5) return GRAY_W'(flat_level);
        case (r)
            0: return 8'd0;
            1: return 8'd255;
            2, 3: return GRAY_W'($urandom_range(120, 136));
            default: return GRAY_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Result side stalls at random.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else if (!quiet_flow && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Every request accepted on any channel goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) sb.note_write(cfg_ch.index, cfg_ch.data);
            if (pixel_ch.valid && pixel_ch.ready) sb.note_pixel(pixel_ch.gray_level);
            if (result_ch.valid && result_ch.ready) begin
                sb.check_result(result_ch.halftone_value, result_ch.row_end,
                                result_ch.image_end);
            end
        end
    end

    task automatic send_pixel(input logic [GRAY_W-1:0] gray);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            pixel_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        pixel_ch.valid      <= 1'b1;
        pixel_ch.gray_level <= gray;
        do @(posedge i_clk); while (!pixel_ch.ready);
        pixels_sent++;
    endtask

    task automatic release_pixels();
        @(negedge i_clk);
        pixel_ch.valid <= 1'b0;
    endtask

    task automatic run_pixels(input int count, input int flat_level);
        repeat (count) send_pixel(pick_gray(flat_level));
        release_pixels();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every expected result has come out.
    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int w, h, n, flat;
        sb = new();
        i_rst_n             = 1'b0;
        pixel_ch.valid      = 1'b0;
        pixel_ch.gray_level = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_IMAGE_WIDTH;
        cfg_ch.data         = '0;
        result_ch.ready     = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sizes left at their reset values; the first row runs from the far right.
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        release_pixels();
        settle();

        // Oversized width clamps to the full line and zero height acts as one row,
        // both changed in the middle of an image.
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        write_reg(REG_IMAGE_HEIGHT, 16'h0000);
        send_pixel(8'd255);
        send_pixel(8'd127);
        send_pixel(8'd0);
        send_pixel(8'd128);
        release_pixels();
        settle();

        // Zero width: the column counter is past the end, so this pixel ends the image.
        write_reg(REG_IMAGE_WIDTH, 16'h0000);
        send_pixel(8'd77);
        release_pixels();
        settle();

        // Writes beyond the register list must change nothing.
        write_reg(REG_UNUSED_FIRST, 16'hFFFF);
        write_reg(REG_UNUSED_LAST, 16'h0003);

        // A whole small image, both directions and all edges.
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd127);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd200);
        release_pixels();
        settle();

        // Single column of two rows.
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        send_pixel(8'd128);
        send_pixel(8'd127);
        release_pixels();
        settle();

        // Random phases: mostly whole images of small sizes, some left unfinished.
        while (pixels_sent < PIXEL_TARGET) begin
            quiet_flow = ($urandom_range(0, 4) == 0);
            flat = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255)) : -1;
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                          CFG_DATA_W'($urandom));
            end
            if ($urandom_range(0, 11) == 0) begin
                // Arbitrary register values, usually large; only part of the image is sent.
                write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom));
                write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom));
                run_pixels($urandom_range(5, 40), flat);
            end else begin
                w = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(1, 12));
                h = ($urandom_range(0, 15) == 0) ? 0 : int'($urandom_range(1, 6));
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
                end else begin
                    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
                    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
                end
                n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * int'($urandom_range(1, 4));
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 8);
                run_pixels(n, flat);
            end
            settle();
        end

        quiet_flow = 1'b0;
        settle();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run, line-buffer sweeps included.
    initial begin
        #30_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
